// File: design/assert_macros.svh
// Assertion helpers included by the top-level design file.
// Each macro samples on the rising edge of i_clk and is disabled while reset is held.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// A condition that must hold in the same cycle as its trigger.
`define ASSERT_SAME(label, trig, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |-> (cond)) \
        else $error(msg);

// A condition that must hold in the cycle after its trigger.
`define ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

// File: design/urbift_pkg.sv
`timescale 1ns / 1ps

package urbift_pkg;

    // Request codes carried on the input word.
    typedef enum logic [2:0] {
        REQ_PUSH    = 3'd0,
        REQ_POP     = 3'd1,
        REQ_RXBYTE  = 3'd2,
        REQ_TXREADY = 3'd3,
        REQ_TICK    = 3'd4
    } t_req;

    // Status codes returned with each result word.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // Configuration register indexes.
    localparam logic [1:0] CFG_IDLE_TICKS  = 2'd0;
    localparam logic [1:0] CFG_HALF_DUPLEX = 2'd1;

    // Register reset values.
    localparam logic [15:0] IDLE_TICKS_RESET  = 16'd10;
    localparam logic        HALF_DUPLEX_RESET = 1'b1;

    // FIFO occupancy flags handed from a FIFO to the controller.
    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_flags;

endpackage

// File: design/urbift_ram.sv
`timescale 1ns / 1ps

module urbift_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port; read data holds when not reading.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/urbift_fifo.sv
`timescale 1ns / 1ps

module urbift_fifo import urbift_pkg::*; #(
    parameter int DEPTH = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [7:0]                 i_wr_data,
    input  logic                       i_pop,
    output logic [7:0]                 o_rd_data,
    output logic [$clog2(DEPTH+1)-1:0] o_count,
    output t_fifo_flags                o_flags
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [PTR_W-1:0] r_head, n_head;
    logic [PTR_W-1:0] r_tail, n_tail;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_push;
    logic             w_pop;

    // Guard the requests against overflow and underflow.
    assign o_flags.full  = (r_count == CNT_W'(DEPTH));
    assign o_flags.empty = (r_count == '0);
    assign w_push = i_push && !o_flags.full;
    assign w_pop  = i_pop && !o_flags.empty;

    // Pointers wrap at the depth, which need not be a power of two.
    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (w_push) begin
            n_head = (r_head == PTR_W'(DEPTH - 1)) ? '0 : r_head + 1'b1;
        end
        if (w_pop) begin
            n_tail = (r_tail == PTR_W'(DEPTH - 1)) ? '0 : r_tail + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    // Storage: the popped word appears on the read port in the cycle after the pop.
    urbift_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_push),
        .i_waddr (r_head),
        .i_wdata (i_wr_data),
        .i_re    (w_pop),
        .i_raddr (r_tail),
        .o_rdata (o_rd_data)
    );

    assign o_count = r_count;

endmodule

// File: design/uart_ring_buffers_idle_frame_timer.sv
`timescale 1ns / 1ps
// An accepted request word's result word is registered for the next cycle.
// One request per cycle unless the result stalls; its register frees when taken.
// Each FIFO push or pop updates a pointer and count and reads or writes one entry.
// Synchronous active-low reset empties both FIFOs, clears the idle timer and the
// transmitting flag, and loads idle_ticks with 10 and half_duplex with 1.
`include "assert_macros.svh"

module uart_ring_buffers_idle_frame_timer import urbift_pkg::*; #(
    parameter int TX_DEPTH = 64,
    parameter int RX_DEPTH = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Request channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [2:0]                    i_req_type,
    input  logic [7:0]                    i_data_byte,
    // Result channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [7:0]                    o_out_byte,
    output logic [1:0]                    o_status,
    output logic                          o_send_byte,
    output logic                          o_transmitting,
    output logic                          o_frame_done,
    output logic [$clog2(RX_DEPTH+1)-1:0] o_rx_level,
    output logic [$clog2(TX_DEPTH+1)-1:0] o_tx_level,
    // Configuration channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [1:0]                    i_cfg_index,
    input  logic [15:0]                   i_cfg_data
);

    typedef enum logic [1:0] {
        SRC_NONE,
        SRC_RX,
        SRC_TX
    } t_byte_src;

    logic        w_accept;
    t_req        w_req;
    t_fifo_flags w_tx_flags;
    t_fifo_flags w_rx_flags;
    logic [7:0]  w_tx_rd_data;
    logic [7:0]  w_rx_rd_data;
    logic        w_tx_push;
    logic        w_tx_pop;
    logic        w_rx_push;
    logic        w_rx_pop;
    logic        w_rx_take;
    logic        w_tick;

    logic [15:0] r_idle_ticks;
    logic        r_half_duplex;
    logic [15:0] r_idle_timer, n_idle_timer;
    logic        r_tx_active, n_tx_active;

    logic        r_valid;
    t_status     r_status, n_status;
    t_byte_src   r_src, n_src;
    logic        r_send, n_send;
    logic        r_done, n_done;

    // The result register frees in the cycle its word is taken.
    assign o_in_stall = r_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_req      = t_req'(i_req_type);

    // Configuration is always accepted.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_ticks  <= IDLE_TICKS_RESET;
            r_half_duplex <= HALF_DUPLEX_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_IDLE_TICKS:  r_idle_ticks  <= i_cfg_data;
                CFG_HALF_DUPLEX: r_half_duplex <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Request decode into FIFO operations.
    assign w_tx_push = w_accept && (w_req == REQ_PUSH);
    assign w_tx_pop  = w_accept && (w_req == REQ_TXREADY);
    assign w_rx_pop  = w_accept && (w_req == REQ_POP);
    assign w_rx_take = w_accept && (w_req == REQ_RXBYTE) && !(r_half_duplex && r_tx_active);
    assign w_rx_push = w_rx_take;
    assign w_tick    = w_accept && (w_req == REQ_TICK);

    urbift_fifo #(
        .DEPTH (TX_DEPTH)
    ) u_tx_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (w_tx_push),
        .i_wr_data (i_data_byte),
        .i_pop     (w_tx_pop),
        .o_rd_data (w_tx_rd_data),
        .o_count   (o_tx_level),
        .o_flags   (w_tx_flags)
    );

    urbift_fifo #(
        .DEPTH (RX_DEPTH)
    ) u_rx_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (w_rx_push),
        .i_wr_data (i_data_byte),
        .i_pop     (w_rx_pop),
        .o_rd_data (w_rx_rd_data),
        .o_count   (o_rx_level),
        .o_flags   (w_rx_flags)
    );

    // Idle timer, transmit flag and the result fields of this request.
    always_comb begin
        n_idle_timer = r_idle_timer;
        n_tx_active  = r_tx_active;
        n_status     = ST_OK;
        n_src        = SRC_NONE;
        n_send       = 1'b0;
        n_done       = 1'b0;
        if (w_rx_take) begin
            n_idle_timer = r_idle_ticks;
        end else if (w_tick && (r_idle_timer != '0)) begin
            n_idle_timer = r_idle_timer - 1'b1;
            n_done       = (r_idle_timer == 16'd1);
        end
        case (w_req)
            REQ_PUSH: begin
                if (w_tx_flags.full) begin
                    n_status = ST_FULL;
                end
            end
            REQ_POP: begin
                if (w_rx_flags.empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_src = SRC_RX;
                end
            end
            REQ_TXREADY: begin
                if (w_tx_flags.empty) begin
                    n_status    = ST_EMPTY;
                    n_tx_active = 1'b0;
                end else begin
                    n_src       = SRC_TX;
                    n_send      = 1'b1;
                    n_tx_active = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_timer <= '0;
            r_tx_active  <= 1'b0;
            r_valid      <= 1'b0;
        end else begin
            if (w_accept) begin
                r_idle_timer <= n_idle_timer;
                r_tx_active  <= n_tx_active;
                r_valid      <= 1'b1;
            end else if (!i_out_stall) begin
                r_valid      <= 1'b0;
            end
        end
    end

    // Result payload; the popped byte comes from the RAM read register.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= n_status;
            r_src    <= n_src;
            r_send   <= n_send;
            r_done   <= n_done;
        end
    end

    always_comb begin
        case (r_src)
            SRC_RX:  o_out_byte = w_rx_rd_data;
            SRC_TX:  o_out_byte = w_tx_rd_data;
            default: o_out_byte = 8'd0;
        endcase
    end

    // Levels and the flag are only updated on accept, so they match the held word.
    assign o_out_valid    = r_valid;
    assign o_status       = r_status;
    assign o_send_byte    = r_send;
    assign o_frame_done   = r_done;
    assign o_transmitting = r_tx_active;

    // A byte handed to the line always comes with ok status and the flag set.
    `ASSERT_SAME(a_send_sets_active, r_valid && r_send,
        r_tx_active && (r_status == ST_OK), "send without transmitting")

    // A push into a full transmit FIFO reports full.
    `ASSERT_NEXT(a_push_full, w_accept && (w_req == REQ_PUSH) && w_tx_flags.full,
        r_status == ST_FULL, "full push not reported")

    // The frame end is flagged only when the timer has just run out.
    `ASSERT_SAME(a_done_timer_zero, r_valid && r_done,
        r_idle_timer == '0, "frame end with running timer")

    // The FIFO levels never pass their depths.
    `ASSERT_ALWAYS(a_levels_bound,
        (o_rx_level <= ($clog2(RX_DEPTH+1))'(RX_DEPTH))
            && (o_tx_level <= ($clog2(TX_DEPTH+1))'(TX_DEPTH)),
        "FIFO level out of range")

endmodule
